// File: rtl/core/mots_pkg.sv
// ----------------------------------------------------------------------------
// mots_pkg
// Shared types and codes for the most-overdue task scheduler.
// ----------------------------------------------------------------------------
package mots_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int ID_BITS_DEF   = 8;
    localparam int TIME_W        = 32;
    localparam int TASK_ID_W     = 8;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // row-wide command broadcast to every cell
    typedef struct packed {
        logic       resync;   // time went backwards: last run <= now
        logic       shift;    // close a gap at and above rm_pos
        logic       append;   // write new task at append position
        logic       stamp;    // last run <= now at grant position
    } cell_cmd_t;

endpackage

// File: rtl/core/mots_cell.sv
// ----------------------------------------------------------------------------
// mots_cell
// One task slot. Holds id, interval, max run and last run, passes its
// contents down to the lower neighbor on a remove, and exposes its stored fields.
// ----------------------------------------------------------------------------
module mots_cell #(
    parameter int ID_BITS = mots_pkg::ID_BITS_DEF
) (
    input  logic                        aclk,
    input  mots_pkg::cell_cmd_t         cmd,
    input  logic                        sel_append,
    input  logic                        sel_shift,
    input  logic                        sel_stamp,
    input  logic [ID_BITS-1:0]          new_id,
    input  logic [mots_pkg::TIME_W-1:0] new_interval,
    input  logic [mots_pkg::TIME_W-1:0] new_max_run,
    input  logic [mots_pkg::TIME_W-1:0] now,
    input  logic [ID_BITS-1:0]          up_id,
    input  logic [mots_pkg::TIME_W-1:0] up_interval,
    input  logic [mots_pkg::TIME_W-1:0] up_max_run,
    input  logic [mots_pkg::TIME_W-1:0] up_last_run,
    output logic [ID_BITS-1:0]          id,
    output logic [mots_pkg::TIME_W-1:0] interval,
    output logic [mots_pkg::TIME_W-1:0] max_run,
    output logic [mots_pkg::TIME_W-1:0] last_run
);

    logic [ID_BITS-1:0]          id_reg;
    logic [mots_pkg::TIME_W-1:0] interval_reg;
    logic [mots_pkg::TIME_W-1:0] max_run_reg;
    logic [mots_pkg::TIME_W-1:0] last_run_reg;

    always_ff @(posedge aclk) begin
        if (cmd.append && sel_append) begin
            id_reg       <= new_id;
            interval_reg <= new_interval;
            max_run_reg  <= new_max_run;
            last_run_reg <= now;
        end else if (cmd.shift && sel_shift) begin
            id_reg       <= up_id;
            interval_reg <= up_interval;
            max_run_reg  <= up_max_run;
            last_run_reg <= up_last_run;
        end else if (cmd.resync || (cmd.stamp && sel_stamp)) begin
            last_run_reg <= now;
        end
    end

    assign id       = id_reg;
    assign interval = interval_reg;
    assign max_run  = max_run_reg;
    assign last_run = last_run_reg;

endmodule

// File: rtl/core/most_overdue_task_scheduler_core.sv
// ----------------------------------------------------------------------------
// most_overdue_task_scheduler_core
// Periodic task table with most-overdue selection on every tick.
//
// Input channel s_*: opcode tick / add / remove with task fields and now_ms.
// Result channel m_*: one result per input transfer (status, grant, timing).
// Add and remove results appear in the cycle after the transfer. A tick walks the task cells one per
// cycle with a single overrun compare unit, after an S_RESYNC step when time
// went backwards, and then registers its result from S_OUT. One item is in
// work at a time.
// The result sits in an output register; while the receiver stalls, the
// result holds and no new transfer is taken.
// Reset (synchronous, aresetn low) empties the table and clears the kill,
// start, overrun and previous tick times. Slot contents are not cleared.
// ----------------------------------------------------------------------------
module most_overdue_task_scheduler_core #(
    parameter int MAX_TASKS = mots_pkg::MAX_TASKS_DEF,
    parameter int ID_BITS   = mots_pkg::ID_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_opcode,
    input  logic [mots_pkg::TASK_ID_W-1:0] s_task_id,
    input  logic [mots_pkg::TIME_W-1:0]    s_interval_ms,
    input  logic [mots_pkg::TIME_W-1:0]    s_max_run_ms,
    input  logic [mots_pkg::TIME_W-1:0]    s_now_ms,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_status,
    output logic                           m_granted,
    output logic [mots_pkg::TASK_ID_W-1:0] m_granted_task,
    output logic [mots_pkg::TIME_W-1:0]    m_overrun_ms,
    output logic [mots_pkg::TIME_W-1:0]    m_kill_at_ms,
    output logic                           m_expired,
    output logic [mots_pkg::TIME_W-1:0]    m_runtime_ms,
    output logic [mots_pkg::TIME_W-1:0]    m_delay_ms
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int TW    = mots_pkg::TIME_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RESYNC = 4'b0010,
        S_SCAN   = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [TW-1:0]        prev_tick_reg, kill_reg, start_reg, saved_over_reg;
    logic [TW-1:0]        now_reg;
    logic [CNT_W-1:0]     scan_reg;
    logic [IDX_W-1:0]     best_reg;
    logic [TW-1:0]        best_over_reg;
    logic                 found_reg;

    logic [ID_BITS-1:0]   cid  [MAX_TASKS];
    logic [TW-1:0]        civl [MAX_TASKS];
    logic [TW-1:0]        cmax [MAX_TASKS];
    logic [TW-1:0]        clr  [MAX_TASKS];

    logic [IDX_W-1:0]     rm_pos;
    logic                 rm_hit;
    logic                 accept, out_fire;
    mots_pkg::cell_cmd_t  cmd;
    logic [ID_BITS-1:0]   in_id;
    logic [TW-1:0]        now_sel;

    assign accept   = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;
    assign s_ready  = (state_reg == S_IDLE) && !m_valid;
    assign in_id    = ID_BITS'(s_task_id);

    // first matching id for remove
    always_comb begin
        rm_hit = 1'b0;
        rm_pos = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < count_reg) && (cid[i] == in_id)) begin
                rm_hit = 1'b1;
                rm_pos = IDX_W'(i);
            end
        end
    end

    logic [IDX_W-1:0] scan_idx;
    logic [TW-1:0]    when_t, over_t;
    logic             scan_better;
    assign scan_idx    = scan_reg[IDX_W-1:0];
    assign when_t      = clr[scan_idx] + civl[scan_idx];
    assign over_t      = now_reg - when_t;
    assign scan_better = (when_t <= now_reg) && (over_t > best_over_reg);

    always_comb begin
        cmd.resync = (state_reg == S_RESYNC);
        cmd.shift  = accept && (s_opcode == mots_pkg::OP_REMOVE) && rm_hit;
        cmd.append = accept && (s_opcode == mots_pkg::OP_ADD)
                     && (count_reg < CNT_W'(MAX_TASKS));
        cmd.stamp  = (state_reg == S_OUT) && found_reg;
        now_sel    = (state_reg == S_IDLE) ? s_now_ms : now_reg;
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        localparam int UP = (g + 1 < MAX_TASKS) ? g + 1 : g;
        mots_cell #(.ID_BITS(ID_BITS)) u_cell (
            .aclk         (aclk),
            .cmd          (cmd),
            .sel_append   (count_reg == CNT_W'(g)),
            .sel_shift    (IDX_W'(g) >= rm_pos),
            .sel_stamp    (best_reg == IDX_W'(g)),
            .new_id       (in_id),
            .new_interval (s_interval_ms),
            .new_max_run  (s_max_run_ms),
            .now          (now_sel),
            .up_id        (cid[UP]),
            .up_interval  (civl[UP]),
            .up_max_run   (cmax[UP]),
            .up_last_run  (clr[UP]),
            .id           (cid[g]),
            .interval     (civl[g]),
            .max_run      (cmax[g]),
            .last_run     (clr[g])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept && s_opcode == mots_pkg::OP_TICK) begin
                    state_next = (s_now_ms < prev_tick_reg) ? S_RESYNC : S_SCAN;
                end
            end
            S_RESYNC: state_next = S_SCAN;
            S_SCAN: begin
                if (scan_reg >= count_reg) begin
                    state_next = S_OUT;
                end
            end
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    logic [TW-1:0] kill_n, start_n, sover_n;
    always_comb begin
        kill_n  = kill_reg;
        start_n = start_reg;
        sover_n = saved_over_reg;
        if (cmd.stamp) begin
            kill_n  = cmax[best_reg] + now_reg;
            start_n = now_reg;
            sover_n = best_over_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            prev_tick_reg  <= '0;
            kill_reg       <= '0;
            start_reg      <= '0;
            saved_over_reg <= '0;
            m_valid        <= 1'b0;
            found_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            kill_reg       <= kill_n;
            start_reg      <= start_n;
            saved_over_reg <= sover_n;
            if (out_fire) begin
                m_valid <= 1'b0;
            end
            if (cmd.append) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.shift) begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (accept && s_opcode == mots_pkg::OP_TICK) begin
                prev_tick_reg <= s_now_ms;
                found_reg     <= 1'b0;
            end
            if (state_reg == S_SCAN && scan_reg < count_reg && scan_better) begin
                found_reg <= 1'b1;
            end
            if (accept && s_opcode != mots_pkg::OP_TICK) begin
                m_valid <= 1'b1;
            end
            if (state_reg == S_OUT) begin
                m_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            now_reg       <= s_now_ms;
            scan_reg      <= '0;
            best_reg      <= '0;
            best_over_reg <= '0;
        end else if (state_reg == S_SCAN && scan_reg < count_reg) begin
            scan_reg <= scan_reg + CNT_W'(1);
            if (scan_better) begin
                best_reg      <= scan_idx;
                best_over_reg <= over_t;
            end
        end
        if (accept && s_opcode != mots_pkg::OP_TICK) begin
            m_status       <= (s_opcode == mots_pkg::OP_ADD && !cmd.append)
                              ? mots_pkg::ST_FULL
                              : (s_opcode == mots_pkg::OP_REMOVE && !rm_hit)
                              ? mots_pkg::ST_NOT_FOUND : mots_pkg::ST_OK;
            m_granted      <= 1'b0;
            m_granted_task <= '0;
            m_overrun_ms   <= '0;
            m_kill_at_ms   <= kill_reg;
            m_expired      <= (s_now_ms >= kill_reg);
            m_runtime_ms   <= s_now_ms - start_reg;
            m_delay_ms     <= saved_over_reg;
        end else if (state_reg == S_OUT) begin
            m_status       <= mots_pkg::ST_OK;
            m_granted      <= found_reg;
            m_granted_task <= found_reg ? mots_pkg::TASK_ID_W'(cid[best_reg]) : '0;
            m_overrun_ms   <= found_reg ? best_over_reg : '0;
            m_kill_at_ms   <= kill_n;
            m_expired      <= (now_reg >= kill_n);
            m_runtime_ms   <= now_reg - start_n;
            m_delay_ms     <= sover_n;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count beyond table size");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("input ready while a tick is in work");
    a_out_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT) |=> m_valid)
        else $error("tick finished without a result");
    a_grant_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_granted) |-> (m_overrun_ms != '0))
        else $error("grant with zero overrun");

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the most-overdue task scheduler core. A directed table (reset
// values, full table, missing id, duplicates, time going backwards, wrap) is
// followed by random add/remove/tick traffic with random idling on both
// channels. Every result transfer is checked against a scheduler model.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK = 16;
    localparam int WATCHDOG = 2000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] ivl;
        logic [31:0] mrun;
        logic [31:0] now;
    } sched_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        granted;
        logic [7:0]  gtask;
        logic [31:0] overrun;
        logic [31:0] kill_at;
        logic        expired;
        logic [31:0] runtime;
        logic [31:0] delay;
    } sched_res_t;

    typedef struct {
        sched_cmd_t cmd;
        logic       fixed;
        sched_res_t res;
    } dir_row_t;

    logic aclk = 1'b0, aresetn = 1'b0;
    logic s_valid = 1'b0, m_ready = 1'b0;
    logic s_ready, m_valid;
    logic [1:0] s_opcode = '0;
    logic [7:0] s_task_id = '0;
    logic [31:0] s_interval_ms = '0, s_max_run_ms = '0, s_now_ms = '0;
    logic [1:0] m_status;
    logic m_granted, m_expired;
    logic [7:0] m_granted_task;
    logic [31:0] m_overrun_ms, m_kill_at_ms, m_runtime_ms, m_delay_ms;

    most_overdue_task_scheduler_core uut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // scheduler model state
    logic [7:0]  tab_id [NTASK];
    logic [31:0] tab_ivl [NTASK], tab_mrun [NTASK], tab_last [NTASK];
    int          tab_cnt;
    logic [31:0] prev_tick, kill_t, start_t, saved_ovr;

    sched_res_t pending_res[$];
    int errors = 0, mismatches = 0;
    int idle_cnt = 0;
    bit calm = 0;
    bit done = 0;

    function automatic sched_res_t schedule_step(sched_cmd_t c);
        sched_res_t r;
        logic [31:0] when, over, best_over;
        int best;
        int k;
        r = '0;
        best = -1;
        best_over = '0;
        case (c.op)
            mots_pkg::OP_TICK: begin
                if (prev_tick > c.now)
                    for (k = 0; k < tab_cnt; k++) tab_last[k] = c.now;
                prev_tick = c.now;
                for (k = 0; k < tab_cnt; k++) begin
                    when = tab_last[k] + tab_ivl[k];
                    if (when <= c.now) begin
                        over = c.now - when;
                        if (over > best_over) begin
                            best_over = over;
                            best = k;
                        end
                    end
                end
                if (best >= 0) begin
                    kill_t = tab_mrun[best] + c.now;
                    start_t = c.now;
                    saved_ovr = best_over;
                    tab_last[best] = c.now;
                    r.granted = 1'b1;
                    r.gtask = tab_id[best];
                    r.overrun = best_over;
                end
            end
            mots_pkg::OP_ADD: begin
                if (tab_cnt >= NTASK) r.status = mots_pkg::ST_FULL;
                else begin
                    tab_id[tab_cnt] = c.id;
                    tab_ivl[tab_cnt] = c.ivl;
                    tab_mrun[tab_cnt] = c.mrun;
                    tab_last[tab_cnt] = c.now;
                    tab_cnt++;
                end
            end
            mots_pkg::OP_REMOVE: begin
                r.status = mots_pkg::ST_NOT_FOUND;
                for (k = 0; k < tab_cnt; k++)
                    if (r.status == mots_pkg::ST_NOT_FOUND && tab_id[k] == c.id) begin
                        for (int j = k; j + 1 < tab_cnt; j++) begin
                            tab_id[j] = tab_id[j+1];
                            tab_ivl[j] = tab_ivl[j+1];
                            tab_mrun[j] = tab_mrun[j+1];
                            tab_last[j] = tab_last[j+1];
                        end
                        tab_cnt--;
                        r.status = mots_pkg::ST_OK;
                    end
            end
            default: ;
        endcase
        r.kill_at = kill_t;
        r.expired = (c.now >= kill_t);
        r.runtime = c.now - start_t;
        r.delay = saved_ovr;
        return r;
    endfunction

    task automatic send_cmd(sched_cmd_t c);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge aclk);
        end
        s_opcode <= c.op;
        s_task_id <= c.id;
        s_interval_ms <= c.ivl;
        s_max_run_ms <= c.mrun;
        s_now_ms <= c.now;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_res.push_back(schedule_step(c));
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // result side: random stall bursts, check on transfer
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 14) - 1;
                m_ready <= 1'b0;
            end else
                m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        sched_res_t got, exp_r;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_granted, m_granted_task, m_overrun_ms, m_kill_at_ms,
                    m_expired, m_runtime_ms, m_delay_ms};
            if (pending_res.size() == 0) begin
                errors++;
                if (mismatches++ < 10) $display("unexpected transfer %h", got);
            end else begin
                exp_r = pending_res.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch: exp %h got %h", exp_r, got);
                end
            end
        end
    end

    // watchdog on stalled progress
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || done) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic sched_cmd_t mk(logic [1:0] op, logic [7:0] id, logic [31:0] ivl,
                                      logic [31:0] mrun, logic [31:0] now);
        sched_cmd_t c;
        c = '{op, id, ivl, mrun, now};
        return c;
    endfunction

    function automatic sched_res_t fx(logic [1:0] st, logic [31:0] kill, logic ex,
                                      logic [31:0] rt);
        sched_res_t r;
        r = '{st, 1'b0, 8'd0, 32'd0, kill, ex, rt, 32'd0};
        return r;
    endfunction

    dir_row_t dir_tab[$];
    logic [31:0] clk_ms;
    logic [7:0] live_ids[$];

    initial begin
        sched_cmd_t c;
        int r, n;
        // directed table; fixed rows carry a typed-in result
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd0), 1'b1,
                            fx(mots_pkg::ST_OK, 32'd0, 1'b1, 32'd0)});
        dir_tab.push_back('{mk(mots_pkg::OP_REMOVE, 8'hFF, 32'd0, 32'd0, 32'd5), 1'b1,
                            fx(mots_pkg::ST_NOT_FOUND, 32'd0, 1'b1, 32'd5)});
        dir_tab.push_back('{mk(2'd3, 8'hAA, 32'd0, 32'd0, 32'hFFFFFFFF), 1'b1,
                            fx(mots_pkg::ST_OK, 32'd0, 1'b1, 32'hFFFFFFFF)});
        dir_tab.push_back('{mk(mots_pkg::OP_ADD, 8'h00, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1),
                            1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_ADD, 8'hFF, 32'd0, 32'd0, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_ADD, 8'h11, 32'd10, 32'd100, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_ADD, 8'h11, 32'd10, 32'd7, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd2), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd30), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd31), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd20), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_REMOVE, 8'h11, 32'd0, 32'd0, 32'd21), 1'b0, '0});
        for (int k = 0; k < 14; k++)
            dir_tab.push_back('{mk(mots_pkg::OP_ADD, 8'(k), 32'(k * 3), 32'hFFFFFFF0,
                                   32'hFFFFFFF8), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'd40), 1'b0, '0});
        dir_tab.push_back('{mk(mots_pkg::OP_TICK, 8'h00, 32'd0, 32'd0, 32'h7FFFFFFF), 1'b0,
                            '0});

        tab_cnt = 0;
        prev_tick = '0; kill_t = '0; start_t = '0; saved_ovr = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            send_cmd(dir_tab[i].cmd);
            if (dir_tab[i].fixed) pending_res[$] = dir_tab[i].res;
        end

        // drain before random traffic
        while (pending_res.size() != 0) @(negedge aclk);
        // clear the table via removes of known ids
        while (tab_cnt > 0)
            send_cmd(mk(mots_pkg::OP_REMOVE, tab_id[0], 32'd0, 32'd0, 32'd100));

        clk_ms = $urandom;
        for (n = 0; n < 700; n++) begin
            if (n == 350) while (pending_res.size() != 0) @(negedge aclk);
            if (n == 600) calm = 1;
            r = $urandom_range(0, 99);
            if (r < 3) clk_ms = $urandom;
            else if (r < 6) clk_ms = clk_ms - $urandom_range(1, 1000);
            else clk_ms = clk_ms + $urandom_range(0, 40);
            r = $urandom_range(0, 99);
            if (r < 50)
                c = mk(mots_pkg::OP_TICK, 8'($urandom), $urandom, $urandom, clk_ms);
            else if (r < 75)
                c = mk(mots_pkg::OP_ADD,
                       8'($urandom_range(0, 15) | ($urandom_range(0, 7) == 0 ? $urandom : 0)),
                       ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60),
                       $urandom, clk_ms);
            else if (r < 97)
                c = mk(mots_pkg::OP_REMOVE, (tab_cnt > 0 && $urandom_range(0, 3) != 0) ?
                       tab_id[$urandom_range(0, tab_cnt - 1)] : 8'($urandom),
                       $urandom, $urandom, clk_ms);
            else c = mk(2'd3, 8'($urandom), $urandom, $urandom, clk_ms);
            send_cmd(c);
        end

        while (pending_res.size() != 0) @(negedge aclk);
        repeat (NTASK + 8) @(negedge aclk);
        done = 1;
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: filelist.f
rtl/core/mots_pkg.sv
rtl/core/mots_cell.sv
rtl/core/most_overdue_task_scheduler_core.sv
sim/tb_top.sv
